### hw/rtl/k_way_run_merger_defines.svh
// Assertion macros shared by the merger RTL.
// Include by bare file name; each use stands on a line of its own.
`ifndef K_WAY_RUN_MERGER_DEFINES_SVH
`define K_WAY_RUN_MERGER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KWM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kwm assertion failed");

// Next-cycle implication, checked outside reset.
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kwm assertion failed");

`endif

### hw/rtl/kwm_pkg.sv
// Shared constants, types and state codes for the k-way run merger.
// No dependencies.
package kwm_pkg;

    localparam int CAPACITY    = 1024;
    localparam int MAX_RUNS    = 8;
    localparam int VAL_W       = 32;

    // store address, element count, run index and run count widths
    localparam int AW          = $clog2(CAPACITY);
    localparam int CW          = $clog2(CAPACITY + 1);
    localparam int RIW         = $clog2(MAX_RUNS);
    localparam int RCW         = $clog2(MAX_RUNS + 1);

    // minimum tree over the run heads
    localparam int TREE_LV     = $clog2(MAX_RUNS);
    localparam int TREE_P      = 1 << TREE_LV;
    localparam int TREE_N      = 2 * TREE_P - 1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_POP  = 1'b1;

    typedef enum logic {
        OP_LOAD,
        OP_POP
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic signed [VAL_W-1:0] value;
        logic                    run_start;
        logic                    set_end;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_FILL
    } t_state;

endpackage

### hw/rtl/kwm_front.sv
// Input side: takes beats, decodes the item kind and queues commands.
// Depends on kwm_pkg.
module kwm_front
    import kwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_kind,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_run_start,
    input  logic                    i_set_end,
    input  logic                    i_pop,
    output t_qhead                  o_q
);

    t_cmd           r_q [QUEUE_DEPTH];
    logic [QPW-1:0] r_wptr;
    logic [QPW-1:0] r_rptr;
    logic [QCW-1:0] r_cnt;
    t_cmd           new_cmd;
    logic           push;
    logic           pop;

    assign o_in_stall = (r_cnt == QCW'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_cnt != '0);

    always_comb begin
        new_cmd.op        = (i_kind == KIND_POP) ? OP_POP : OP_LOAD;
        new_cmd.value     = i_value;
        new_cmd.run_start = i_run_start;
        new_cmd.set_end   = i_set_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + QPW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + QPW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= new_cmd;
        end
    end

    assign o_q.valid = (r_cnt != '0);
    assign o_q.cmd   = r_q[r_rptr];

endmodule

### hw/rtl/kwm_min_tree.sv
// Compare tree over the run head values: smallest live head, lowest run on a tie.
// Depends on kwm_pkg.
module kwm_min_tree
    import kwm_pkg::*;
(
    input  logic                    i_live [MAX_RUNS],
    input  logic signed [VAL_W-1:0] i_head_val [MAX_RUNS],
    output logic                    o_valid,
    output logic [RIW-1:0]          o_idx
);

    // heap order: node n has children 2n+1 and 2n+2, leaves from TREE_P-1
    logic                    nd_valid [TREE_N];
    logic signed [VAL_W-1:0] nd_val   [TREE_N];
    logic [RIW-1:0]          nd_idx   [TREE_N];

    for (genvar i = 0; i < TREE_P; i++) begin : g_leaf
        if (i < MAX_RUNS) begin : g_used
            assign nd_valid[TREE_P-1+i] = i_live[i];
            assign nd_val[TREE_P-1+i]   = i_head_val[i];
        end else begin : g_pad
            assign nd_valid[TREE_P-1+i] = 1'b0;
            assign nd_val[TREE_P-1+i]   = '0;
        end
        assign nd_idx[TREE_P-1+i] = RIW'(i);
    end

    for (genvar n = 0; n < TREE_P - 1; n++) begin : g_node
        logic take_r;
        // left child holds the lower run numbers, so it wins a tie
        assign take_r = nd_valid[2*n+2]
                     && (!nd_valid[2*n+1] || (nd_val[2*n+2] < nd_val[2*n+1]));
        assign nd_valid[n] = nd_valid[2*n+1] || nd_valid[2*n+2];
        assign nd_val[n]   = take_r ? nd_val[2*n+2] : nd_val[2*n+1];
        assign nd_idx[n]   = take_r ? nd_idx[2*n+2] : nd_idx[2*n+1];
    end

    assign o_valid = nd_valid[0];
    assign o_idx   = nd_idx[0];

endmodule

### hw/rtl/kwm_back.sv
// Merge engine: value store, run bookkeeping, head registers and result register.
// Depends on kwm_pkg, kwm_min_tree and k_way_run_merger_defines.svh.
`include "k_way_run_merger_defines.svh"

module kwm_back
    import kwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_qhead                  i_q,
    output logic                    o_q_pop,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic signed [VAL_W-1:0] o_out_value,
    output logic                    o_empty_res,
    output logic                    o_final_res,
    output logic                    o_overflow
);

    t_state                  r_state;
    t_state                  n_state;

    logic [VAL_W-1:0]        r_mem [CAPACITY];
    logic [VAL_W-1:0]        r_rdata;

    logic [CW-1:0]           r_head [MAX_RUNS];
    logic [CW-1:0]           r_end  [MAX_RUNS];
    logic signed [VAL_W-1:0] r_hv   [MAX_RUNS];
    logic [RCW-1:0]          r_run_count;
    logic [CW-1:0]           r_load_count;
    logic [CW-1:0]           r_pop_count;
    logic                    r_draining;
    logic                    r_ovf;

    logic [RIW-1:0]          r_pick;
    logic                    r_found;

    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_empty;
    logic                    r_final;
    logic                    r_ovf_out;

    logic                    head_live [MAX_RUNS];
    logic                    tree_valid;
    logic [RIW-1:0]          tree_idx;

    logic                    out_free;
    logic                    do_load;
    logic                    do_pop;
    logic                    new_run;
    logic                    load_live;
    logic                    load_store;
    logic                    load_drop;
    logic                    load_last;
    logic [RCW-1:0]          run_prev_cnt;
    logic [RIW-1:0]          run_new;
    logic [RIW-1:0]          run_prev;
    logic                    emit_pop;
    logic                    last_pop;
    logic                    clear_set;
    logic [CW-1:0]           head_next;
    logic [AW-1:0]           mem_raddr;

    for (genvar r = 0; r < MAX_RUNS; r++) begin : g_live
        assign head_live[r] = (r_head[r] < r_end[r]);
    end

    kwm_min_tree u_tree (
        .i_live     (head_live),
        .i_head_val (r_hv),
        .o_valid    (tree_valid),
        .o_idx      (tree_idx)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        do_load = 1'b0;
        do_pop  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // a pop waits for the result register, a load never does
                if (i_q.valid && (i_q.cmd.op == OP_LOAD || out_free)) begin
                    o_q_pop = 1'b1;
                    if (i_q.cmd.op == OP_POP) begin
                        do_pop  = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        do_load = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (r_draining && r_found && !last_pop) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FILL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- load classification ----------------
    assign new_run      = i_q.cmd.run_start || (r_run_count == '0);
    assign load_live    = do_load && !r_draining;
    assign load_store   = load_live && !r_ovf
                       && !(new_run && (r_run_count >= RCW'(MAX_RUNS)))
                       && !(r_load_count >= CW'(CAPACITY));
    assign load_drop    = load_live && !r_ovf && !load_store;
    assign load_last    = load_live && i_q.cmd.set_end;
    assign run_prev_cnt = r_run_count - RCW'(1);
    assign run_new      = r_run_count[RIW-1:0];
    assign run_prev     = run_prev_cnt[RIW-1:0];

    // ---------------- pop ----------------
    assign emit_pop  = (r_state == S_EMIT) && r_draining && r_found;
    assign last_pop  = ((r_pop_count + CW'(1)) >= r_load_count);
    assign clear_set = (r_state == S_EMIT) && r_draining && (!r_found || last_pop);
    assign head_next = r_head[r_pick] + CW'(1);
    assign mem_raddr = head_next[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_set) begin
            for (int r = 0; r < MAX_RUNS; r++) begin
                r_head[r] <= '0;
                r_end[r]  <= '0;
            end
            r_run_count  <= '0;
            r_load_count <= '0;
            r_pop_count  <= '0;
            r_draining   <= 1'b0;
            r_ovf        <= 1'b0;
        end else begin
            if (load_store) begin
                if (new_run) begin
                    r_head[run_new] <= r_load_count;
                    r_end[run_new]  <= r_load_count + CW'(1);
                    r_run_count     <= r_run_count + RCW'(1);
                end else begin
                    r_end[run_prev] <= r_load_count + CW'(1);
                end
                r_load_count <= r_load_count + CW'(1);
            end
            if (load_drop) begin
                r_ovf <= 1'b1;
            end
            if (load_last) begin
                r_draining  <= 1'b1;
                r_pop_count <= '0;
            end
            if (emit_pop) begin
                r_head[r_pick] <= head_next;
                r_pop_count    <= r_pop_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (do_pop) begin
            r_found <= tree_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_pick <= tree_idx;
        end
    end

    // ---------------- value store and head registers ----------------
    always_ff @(posedge i_clk) begin
        if (load_store) begin
            r_mem[r_load_count[AW-1:0]] <= i_q.cmd.value;
        end
        if (emit_pop) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_store && new_run) begin
            r_hv[run_new] <= i_q.cmd.value;
        end else if (r_state == S_FILL) begin
            // refill the head just advanced; an exhausted run is masked by head_live
            r_hv[r_pick] <= r_rdata;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT) begin
            r_out_value <= emit_pop ? r_hv[r_pick] : '0;
            r_empty     <= !emit_pop;
            r_final     <= emit_pop && last_pop;
            r_ovf_out   <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_empty_res = r_empty;
    assign o_final_res = r_final;
    assign o_overflow  = r_ovf_out;

    // ---------------- checks ----------------
    `KWM_ASSERT_IMPL(a_emit_slot_free, i_clk, i_rst_n, r_state == S_EMIT, !r_out_valid)
    `KWM_ASSERT_IMPL(a_fill_after_emit, i_clk, i_rst_n, r_state == S_FILL, $past(r_state) == S_EMIT)
    `KWM_ASSERT_IMPL(a_pick_live, i_clk, i_rst_n, emit_pop, head_live[r_pick])
    `KWM_ASSERT_IMPL(a_pops_bounded, i_clk, i_rst_n, r_draining, r_pop_count <= r_load_count)
    `KWM_ASSERT_NEXT(a_clear_to_load, i_clk, i_rst_n, clear_set, !r_draining && r_load_count == '0)

endmodule

### hw/rtl/k_way_run_merger.sv
// k-way run merger. In the engine a load beat is handled in the idle state; a pop steps
// through pick, result write and head refill (the refill waits on the registered store
// read), and skips the refill when no head is refilled. A pop's beat passes through the
// command queue, the pick registers and the result register before it reaches the
// outputs. Loads give no result. Reset is synchronous, active low: it clears queue, run
// bookkeeping and the result valid flag. The value memory is not cleared and no clearing pass runs.
module k_way_run_merger
    import kwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_kind,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_run_start,
    input  logic                    i_set_end,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_out_value,
    output logic                    o_empty_res,
    output logic                    o_final_res,
    output logic                    o_overflow
);

    t_qhead q_head;
    logic   q_pop;

    kwm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .i_run_start (i_run_start),
        .i_set_end   (i_set_end),
        .i_pop       (q_pop),
        .o_q         (q_head)
    );

    kwm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q_head),
        .o_q_pop     (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_value (o_out_value),
        .o_empty_res (o_empty_res),
        .o_final_res (o_final_res),
        .o_overflow  (o_overflow)
    );

endmodule
